/* rtl/thermal_safety_interlock_core_assert.svh */
// assertion macros shared by the thermal interlock rtl
`ifndef THERMAL_SAFETY_INTERLOCK_CORE_ASSERT_SVH
`define THERMAL_SAFETY_INTERLOCK_CORE_ASSERT_SVH

// same-cycle implication, checked on every rising edge outside reset
`define TSI_ASSERT_IMP(lbl, pre, post) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (pre) |-> (post)) \
    else $error("tsi assertion failed");

// next-cycle implication
`define TSI_ASSERT_NXT(lbl, pre, post) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (pre) |=> (post)) \
    else $error("tsi assertion failed");

`endif

/* rtl/tsi_pkg.sv */
// types, constants and codes of the thermal interlock
package tsi_pkg;

  localparam int unsigned HISTORY_DEPTH = 10;
  localparam int unsigned HIST_AW = $clog2(HISTORY_DEPTH);

  localparam int unsigned TIME_W = 32;
  localparam int unsigned TEMP_W = 12;
  localparam int unsigned LIM_W  = 11;
  localparam int unsigned HRS_W  = 10;
  localparam int unsigned IVL_W  = 16;
  localparam int unsigned CFG_W  = 16;
  localparam int unsigned CFG_IDX_W = 3;

  localparam logic signed [TEMP_W-1:0] ABSENT_MARK = -12'sd2032;
  localparam logic signed [TEMP_W-1:0] VALID_FLOOR = -12'sd1600;
  localparam logic [TIME_W-1:0] WINDOW_MS   = 32'd300000;
  localparam logic [TIME_W-1:0] MIN_SPAN_MS = 32'd30000;
  localparam logic [TIME_W-1:0] MS_PER_HOUR = 32'd3600000;
  localparam logic [15:0]       MS_PER_MIN  = 16'd60000;

  localparam logic [LIM_W-1:0] RST_MAX_CUBE  = 11'd1680;
  localparam logic [LIM_W-1:0] RST_MAX_RISE  = 11'd80;
  localparam logic [LIM_W-1:0] RST_MAX_WATER = 11'd800;
  localparam logic [HRS_W-1:0] RST_MAX_HOURS = 10'd12;
  localparam logic [IVL_W-1:0] RST_INTERVAL  = 16'd1000;

  typedef enum logic [1:0] {
    CMD_TICK  = 2'd0,
    CMD_START = 2'd1,
    CMD_END   = 2'd2,
    CMD_CLEAR = 2'd3
  } cmd_e;

  typedef enum logic [2:0] {
    FAULT_OK       = 3'd0,
    FAULT_SENSOR   = 3'd1,
    FAULT_OVERTEMP = 3'd2,
    FAULT_WATER    = 3'd3,
    FAULT_RISE     = 3'd4,
    FAULT_RUNTIME  = 3'd5
  } fault_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_MAX_CUBE  = 3'd0,
    CFG_MAX_RISE  = 3'd1,
    CFG_MAX_WATER = 3'd2,
    CFG_MAX_HOURS = 3'd3,
    CFG_INTERVAL  = 3'd4
  } cfg_idx_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_EXEC,
    ST_SCAN,
    ST_DRAIN,
    ST_MUL,
    ST_FIN
  } state_e;

  typedef struct packed {
    logic [TIME_W-1:0] stamp;
    logic [TEMP_W-1:0] temp;
  } sample_t;

  typedef struct packed {
    logic start;
    logic scan_rd;
    logic mul;
  } rise_ctl_t;

  typedef struct packed {
    cmd_e              command;
    logic [TIME_W-1:0] now_ms;
    logic [TEMP_W-1:0] cube_temp;
    logic [TEMP_W-1:0] water_out_temp;
    logic              cube_present;
    logic              reflux_present;
    logic              water_present;
  } in_item_t;

  typedef struct packed {
    logic              system_safe;
    logic [2:0]        fault_code;
    logic [TIME_W-1:0] fault_time;
    logic              sensor_fault;
    logic              thermal_fault;
    logic              coolant_fault;
    logic              runtime_fault;
    logic              emergency;
    logic              shutdown_now;
    logic              process_active;
    logic              clear_accepted;
  } out_item_t;

endpackage

/* rtl/tsi_if.sv */
// command and status channels of the thermal interlock
interface tsi_in_if;
  logic                             valid;
  logic                             ready;
  logic [1:0]                       command;
  logic [tsi_pkg::TIME_W-1:0]       now_ms;
  logic signed [tsi_pkg::TEMP_W-1:0] cube_temp;
  logic signed [tsi_pkg::TEMP_W-1:0] water_out_temp;
  logic                             cube_present;
  logic                             reflux_present;
  logic                             water_present;

  modport source (
    output valid, command, now_ms, cube_temp, water_out_temp,
           cube_present, reflux_present, water_present,
    input  ready
  );
  modport sink (
    input  valid, command, now_ms, cube_temp, water_out_temp,
           cube_present, reflux_present, water_present,
    output ready
  );
endinterface

interface tsi_out_if;
  logic                       valid;
  logic                       ready;
  logic                       system_safe;
  logic [2:0]                 fault_code;
  logic [tsi_pkg::TIME_W-1:0] fault_time;
  logic                       sensor_fault;
  logic                       thermal_fault;
  logic                       coolant_fault;
  logic                       runtime_fault;
  logic                       emergency;
  logic                       shutdown_now;
  logic                       process_active;
  logic                       clear_accepted;

  modport source (
    output valid, system_safe, fault_code, fault_time, sensor_fault, thermal_fault,
           coolant_fault, runtime_fault, emergency, shutdown_now, process_active,
           clear_accepted,
    input  ready
  );
  modport sink (
    input  valid, system_safe, fault_code, fault_time, sensor_fault, thermal_fault,
           coolant_fault, runtime_fault, emergency, shutdown_now, process_active,
           clear_accepted,
    output ready
  );
endinterface

/* rtl/tsi_hist_ram.sv */
// sample history memory, one write and one registered read port
module tsi_hist_ram (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         we_i,
  input  logic [tsi_pkg::HIST_AW-1:0]  waddr_i,
  input  tsi_pkg::sample_t             wdata_i,
  input  logic                         re_i,
  input  logic [tsi_pkg::HIST_AW-1:0]  raddr_i,
  output tsi_pkg::sample_t             rdata_o
);

  tsi_pkg::sample_t                     mem_q [tsi_pkg::HISTORY_DEPTH];
  tsi_pkg::sample_t                     rdata_q;
  logic [tsi_pkg::HISTORY_DEPTH-1:0]    vld_q;
  logic                                 rvld_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  // an entry never written reads as zero time, which marks it invalid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q  <= '0;
      rvld_q <= 1'b0;
    end else begin
      if (we_i) begin
        vld_q[waddr_i] <= 1'b1;
      end
      if (re_i) begin
        rvld_q <= vld_q[raddr_i];
      end
    end
  end

  assign rdata_o = rvld_q ? rdata_q : '0;

endmodule

/* rtl/tsi_rise_chk.sv */
// rise-rate base search over the history and cross-multiplied compare
module tsi_rise_chk (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  tsi_pkg::rise_ctl_t                ctl_i,
  input  tsi_pkg::sample_t                  rdata_i,
  input  logic [tsi_pkg::TIME_W-1:0]        now_i,
  input  logic [tsi_pkg::TEMP_W-1:0]        cur_temp_i,
  input  logic [tsi_pkg::LIM_W-1:0]         max_rise_i,
  output logic                              rise_o
);

  localparam int unsigned LHS_W = 30;
  localparam int unsigned RHS_W = tsi_pkg::TIME_W + tsi_pkg::LIM_W;

  logic                      pend_q;
  logic                      found_q;
  tsi_pkg::sample_t          base_q;
  logic signed [LHS_W-1:0]   lhs_q, lhs_d;
  logic [RHS_W-1:0]          rhs_q, rhs_d;
  logic                      short_q;
  logic                      match;
  logic [tsi_pkg::TIME_W-1:0] age;
  logic [tsi_pkg::TIME_W-1:0] dt;
  logic [tsi_pkg::TEMP_W:0]   diff;
  logic signed [LHS_W-1:0]   diff_w;
  logic signed [LHS_W-1:0]   per_min_w;

  assign age   = now_i - rdata_i.stamp;
  assign match = (rdata_i.stamp != '0) &&
                 ($signed(rdata_i.temp) > tsi_pkg::VALID_FLOOR) &&
                 (age <= tsi_pkg::WINDOW_MS);

  assign dt   = now_i - base_q.stamp;
  assign diff = {cur_temp_i[tsi_pkg::TEMP_W-1], cur_temp_i} -
                {base_q.temp[tsi_pkg::TEMP_W-1], base_q.temp};
  assign diff_w    = {{(LHS_W-tsi_pkg::TEMP_W-1){diff[tsi_pkg::TEMP_W]}}, diff};
  assign per_min_w = $signed({{(LHS_W-16){1'b0}}, tsi_pkg::MS_PER_MIN});
  assign lhs_d     = diff_w * per_min_w;
  assign rhs_d     = RHS_W'(max_rise_i) * RHS_W'(dt);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pend_q  <= 1'b0;
      found_q <= 1'b0;
      short_q <= 1'b0;
    end else begin
      pend_q <= ctl_i.scan_rd;
      if (ctl_i.start) begin
        found_q <= 1'b0;
      end else if (pend_q && match) begin
        found_q <= 1'b1;
      end
      if (ctl_i.mul) begin
        short_q <= dt < tsi_pkg::MIN_SPAN_MS;
      end
    end
  end

  // entries arrive newest first, so the last match is the oldest in the window
  always_ff @(posedge clk_i) begin
    if (pend_q && match) begin
      base_q <= rdata_i;
    end
    if (ctl_i.mul) begin
      lhs_q <= lhs_d;
      rhs_q <= rhs_d;
    end
  end

  assign rise_o = found_q && !short_q &&
                  ($signed({{(RHS_W+1-LHS_W){lhs_q[LHS_W-1]}}, lhs_q}) >
                   $signed({1'b0, rhs_q}));

endmodule

/* rtl/thermal_safety_interlock_core.sv */
// thermal safety interlock: command decode, fault latching and result register
//
// Commands enter on in_if (tick, process start, process end, error clear) and
// each one gives exactly one status item on out_if. A transfer happens when
// valid and ready are both high at a rising clk_i edge.
// Start, end, clear and early ticks go from decode straight to the final step;
// no new command is taken before the last one has left that step.
// Accepted ticks write the sample and walk the other HISTORY_DEPTH-1 history
// entries through the memory read port, one per cycle, then drain the last
// read and multiply before the final step, and take no new tick meanwhile.
// The user must write the limits through cfg_we_i / cfg_idx_i / cfg_data_i only while
// no item is in flight, which the block itself does not enforce; an unknown index is ignored.
// rst_ni clears the history valid bits, pointers and latched flags at once
// (status safe, no fault); there is no clearing pass.
// The status item sits in an output register until taken; while it waits a
// new command is still accepted and worked on, and its result holds in the
// final step until the register is free.
module thermal_safety_interlock_core (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                cfg_we_i,
  input  logic [tsi_pkg::CFG_IDX_W-1:0]       cfg_idx_i,
  input  logic [tsi_pkg::CFG_W-1:0]           cfg_data_i,
  tsi_in_if.sink                              in_if,
  tsi_out_if.source                           out_if
);

  localparam int unsigned DEPTH = tsi_pkg::HISTORY_DEPTH;
  localparam int unsigned AW    = tsi_pkg::HIST_AW;

  tsi_pkg::state_e             state_q, state_d;
  tsi_pkg::in_item_t           item_q;
  tsi_pkg::out_item_t          out_q, out_d;
  logic                        out_valid_q;
  logic                        out_free;
  logic                        fin_go;

  logic [tsi_pkg::LIM_W-1:0]   max_cube_q, max_rise_q, max_water_q;
  logic [tsi_pkg::HRS_W-1:0]   max_hours_q;
  logic [tsi_pkg::IVL_W-1:0]   interval_q;

  logic                        tick_ok_q, tick_ok_d;
  logic [AW-1:0]               cnt_q, cnt_d;
  logic [AW-1:0]               raddr_q, raddr_d;
  logic [AW-1:0]               ptr_q, ptr_d, ptr_nx;
  logic [tsi_pkg::TIME_W-1:0]  last_q, last_d;
  logic [tsi_pkg::TIME_W-1:0]  rt_lim_q, rt_lim_d;

  logic [tsi_pkg::TIME_W-1:0]  start_q, start_d;
  logic                        run_q, run_d;
  logic                        safe_q, safe_d;
  logic                        sensor_q, sensor_d;
  logic                        thermal_q, thermal_d;
  logic                        coolant_q, coolant_d;
  logic                        runtime_q, runtime_d;
  logic                        emerg_q, emerg_d;
  tsi_pkg::fault_e             code_q, code_d;
  logic [tsi_pkg::TIME_W-1:0]  ftime_q, ftime_d;
  logic                        shutdown, cleared;

  logic                        ram_we, ram_re;
  tsi_pkg::sample_t            ram_wdata, ram_rdata;
  tsi_pkg::rise_ctl_t          rise_ctl;
  logic                        rise;
  logic [tsi_pkg::TEMP_W-1:0]  cur_temp;
  logic                        interval_ok;
  logic                        cube_hi, water_hi, runtime_over;
  tsi_pkg::fault_e             tick_code;
  logic                        clear_ok;

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      max_cube_q  <= tsi_pkg::RST_MAX_CUBE;
      max_rise_q  <= tsi_pkg::RST_MAX_RISE;
      max_water_q <= tsi_pkg::RST_MAX_WATER;
      max_hours_q <= tsi_pkg::RST_MAX_HOURS;
      interval_q  <= tsi_pkg::RST_INTERVAL;
    end else if (cfg_we_i) begin
      case (tsi_pkg::cfg_idx_e'(cfg_idx_i))
        tsi_pkg::CFG_MAX_CUBE:  max_cube_q  <= cfg_data_i[tsi_pkg::LIM_W-1:0];
        tsi_pkg::CFG_MAX_RISE:  max_rise_q  <= cfg_data_i[tsi_pkg::LIM_W-1:0];
        tsi_pkg::CFG_MAX_WATER: max_water_q <= cfg_data_i[tsi_pkg::LIM_W-1:0];
        tsi_pkg::CFG_MAX_HOURS: max_hours_q <= cfg_data_i[tsi_pkg::HRS_W-1:0];
        tsi_pkg::CFG_INTERVAL:  interval_q  <= cfg_data_i[tsi_pkg::IVL_W-1:0];
        default: ;
      endcase
    end
  end

  assign in_if.ready = (state_q == tsi_pkg::ST_IDLE);
  assign out_free    = !out_valid_q || out_if.ready;

  assign cur_temp    = item_q.cube_present ? item_q.cube_temp : tsi_pkg::ABSENT_MARK;
  assign interval_ok = (item_q.now_ms - last_q) >= tsi_pkg::TIME_W'(interval_q);
  assign ptr_nx      = (ptr_q == AW'(DEPTH-1)) ? '0 : ptr_q + 1'b1;

  assign ram_wdata.stamp = item_q.now_ms;
  assign ram_wdata.temp  = cur_temp;

  // sequencer: decode, history walk, drain, multiply, retire
  always_comb begin
    state_d   = state_q;
    tick_ok_d = tick_ok_q;
    cnt_d     = cnt_q;
    raddr_d   = raddr_q;
    ptr_d     = ptr_q;
    last_d    = last_q;
    rt_lim_d  = rt_lim_q;
    ram_we    = 1'b0;
    ram_re    = 1'b0;
    rise_ctl  = '0;
    fin_go    = 1'b0;
    case (state_q)
      tsi_pkg::ST_IDLE: begin
        if (in_if.valid) begin
          state_d = tsi_pkg::ST_EXEC;
        end
      end
      tsi_pkg::ST_EXEC: begin
        rt_lim_d = tsi_pkg::TIME_W'(max_hours_q) * tsi_pkg::MS_PER_HOUR;
        if (item_q.command == tsi_pkg::CMD_TICK && interval_ok) begin
          tick_ok_d      = 1'b1;
          ram_we         = 1'b1;
          ptr_d          = ptr_nx;
          last_d         = item_q.now_ms;
          rise_ctl.start = 1'b1;
          raddr_d        = ptr_q;
          cnt_d          = AW'(DEPTH-2);
          state_d        = tsi_pkg::ST_SCAN;
        end else begin
          tick_ok_d = 1'b0;
          state_d   = tsi_pkg::ST_FIN;
        end
      end
      tsi_pkg::ST_SCAN: begin
        ram_re           = 1'b1;
        rise_ctl.scan_rd = 1'b1;
        raddr_d          = (raddr_q == '0) ? AW'(DEPTH-1) : raddr_q - 1'b1;
        cnt_d            = cnt_q - 1'b1;
        if (cnt_q == '0) begin
          state_d = tsi_pkg::ST_DRAIN;
        end
      end
      tsi_pkg::ST_DRAIN: begin
        state_d = tsi_pkg::ST_MUL;
      end
      tsi_pkg::ST_MUL: begin
        rise_ctl.mul = 1'b1;
        state_d      = tsi_pkg::ST_FIN;
      end
      tsi_pkg::ST_FIN: begin
        if (out_free) begin
          fin_go  = 1'b1;
          state_d = tsi_pkg::ST_IDLE;
        end
      end
      default: begin
        state_d = tsi_pkg::ST_IDLE;
      end
    endcase
  end

  // fault checks in priority order
  assign cube_hi  = $signed({item_q.cube_temp[tsi_pkg::TEMP_W-1], item_q.cube_temp}) >
                    $signed({2'b00, max_cube_q});
  assign water_hi = $signed({item_q.water_out_temp[tsi_pkg::TEMP_W-1],
                             item_q.water_out_temp}) > $signed({2'b00, max_water_q});
  assign runtime_over = (item_q.now_ms - start_q) > rt_lim_q;

  always_comb begin
    if (!item_q.cube_present || !item_q.reflux_present) begin
      tick_code = tsi_pkg::FAULT_SENSOR;
    end else if (cube_hi) begin
      tick_code = tsi_pkg::FAULT_OVERTEMP;
    end else if (item_q.water_present && water_hi) begin
      tick_code = tsi_pkg::FAULT_WATER;
    end else if (rise) begin
      tick_code = tsi_pkg::FAULT_RISE;
    end else if (runtime_over) begin
      tick_code = tsi_pkg::FAULT_RUNTIME;
    end else begin
      tick_code = tsi_pkg::FAULT_OK;
    end
  end

  assign clear_ok = !sensor_q && !emerg_q;

  // latched status after this command
  always_comb begin
    start_d   = start_q;
    run_d     = run_q;
    safe_d    = safe_q;
    sensor_d  = sensor_q;
    thermal_d = thermal_q;
    coolant_d = coolant_q;
    runtime_d = runtime_q;
    emerg_d   = emerg_q;
    code_d    = code_q;
    ftime_d   = ftime_q;
    shutdown  = 1'b0;
    cleared   = 1'b0;
    case (item_q.command)
      tsi_pkg::CMD_TICK: begin
        if (tick_ok_q && run_q && tick_code != tsi_pkg::FAULT_OK) begin
          safe_d  = 1'b0;
          code_d  = tick_code;
          ftime_d = item_q.now_ms;
          case (tick_code)
            tsi_pkg::FAULT_SENSOR: sensor_d = 1'b1;
            tsi_pkg::FAULT_OVERTEMP, tsi_pkg::FAULT_RISE: thermal_d = 1'b1;
            tsi_pkg::FAULT_WATER: coolant_d = 1'b1;
            default: runtime_d = 1'b1;
          endcase
          if (tick_code == tsi_pkg::FAULT_OVERTEMP || tick_code == tsi_pkg::FAULT_WATER) begin
            emerg_d  = 1'b1;
            run_d    = 1'b0;
            shutdown = 1'b1;
          end
        end
      end
      tsi_pkg::CMD_START, tsi_pkg::CMD_CLEAR: begin
        if (item_q.command == tsi_pkg::CMD_START) begin
          start_d = item_q.now_ms;
          run_d   = 1'b1;
        end
        if (clear_ok) begin
          safe_d    = 1'b1;
          thermal_d = 1'b0;
          coolant_d = 1'b0;
          runtime_d = 1'b0;
          code_d    = tsi_pkg::FAULT_OK;
          cleared   = 1'b1;
        end
      end
      tsi_pkg::CMD_END: begin
        run_d = 1'b0;
      end
      default: ;
    endcase
  end

  always_comb begin
    out_d.system_safe    = safe_d;
    out_d.fault_code     = code_d;
    out_d.fault_time     = ftime_d;
    out_d.sensor_fault   = sensor_d;
    out_d.thermal_fault  = thermal_d;
    out_d.coolant_fault  = coolant_d;
    out_d.runtime_fault  = runtime_d;
    out_d.emergency      = emerg_d;
    out_d.shutdown_now   = shutdown;
    out_d.process_active = run_d;
    out_d.clear_accepted = cleared;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= tsi_pkg::ST_IDLE;
      tick_ok_q   <= 1'b0;
      cnt_q       <= '0;
      raddr_q     <= '0;
      ptr_q       <= '0;
      last_q      <= '0;
      rt_lim_q    <= '0;
      start_q     <= '0;
      run_q       <= 1'b0;
      safe_q      <= 1'b1;
      sensor_q    <= 1'b0;
      thermal_q   <= 1'b0;
      coolant_q   <= 1'b0;
      runtime_q   <= 1'b0;
      emerg_q     <= 1'b0;
      code_q      <= tsi_pkg::FAULT_OK;
      ftime_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      tick_ok_q <= tick_ok_d;
      cnt_q     <= cnt_d;
      raddr_q   <= raddr_d;
      ptr_q     <= ptr_d;
      last_q    <= last_d;
      rt_lim_q  <= rt_lim_d;
      if (fin_go) begin
        start_q   <= start_d;
        run_q     <= run_d;
        safe_q    <= safe_d;
        sensor_q  <= sensor_d;
        thermal_q <= thermal_d;
        coolant_q <= coolant_d;
        runtime_q <= runtime_d;
        emerg_q   <= emerg_d;
        code_q    <= code_d;
        ftime_q   <= ftime_d;
      end
      if (fin_go) begin
        out_valid_q <= 1'b1;
      end else if (out_if.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_if.valid && in_if.ready) begin
      item_q.command        <= tsi_pkg::cmd_e'(in_if.command);
      item_q.now_ms         <= in_if.now_ms;
      item_q.cube_temp      <= in_if.cube_temp;
      item_q.water_out_temp <= in_if.water_out_temp;
      item_q.cube_present   <= in_if.cube_present;
      item_q.reflux_present <= in_if.reflux_present;
      item_q.water_present  <= in_if.water_present;
    end
    if (fin_go) begin
      out_q <= out_d;
    end
  end

  tsi_hist_ram u_hist_ram (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .we_i    (ram_we),
    .waddr_i (ptr_nx),
    .wdata_i (ram_wdata),
    .re_i    (ram_re),
    .raddr_i (raddr_q),
    .rdata_o (ram_rdata)
  );

  tsi_rise_chk u_rise_chk (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .ctl_i      (rise_ctl),
    .rdata_i    (ram_rdata),
    .now_i      (item_q.now_ms),
    .cur_temp_i (cur_temp),
    .max_rise_i (max_rise_q),
    .rise_o     (rise)
  );

  assign out_if.valid          = out_valid_q;
  assign out_if.system_safe    = out_q.system_safe;
  assign out_if.fault_code     = out_q.fault_code;
  assign out_if.fault_time     = out_q.fault_time;
  assign out_if.sensor_fault   = out_q.sensor_fault;
  assign out_if.thermal_fault  = out_q.thermal_fault;
  assign out_if.coolant_fault  = out_q.coolant_fault;
  assign out_if.runtime_fault  = out_q.runtime_fault;
  assign out_if.emergency      = out_q.emergency;
  assign out_if.shutdown_now   = out_q.shutdown_now;
  assign out_if.process_active = out_q.process_active;
  assign out_if.clear_accepted = out_q.clear_accepted;

`include "thermal_safety_interlock_core_assert.svh"

  `TSI_ASSERT_IMP(a_emerg_unsafe, emerg_q, !safe_q)
  `TSI_ASSERT_IMP(a_safe_no_code, safe_q, code_q == tsi_pkg::FAULT_OK)
  `TSI_ASSERT_IMP(a_ptr_range, ram_we, ptr_q < AW'(DEPTH))
  `TSI_ASSERT_NXT(a_fin_loads, state_q == tsi_pkg::ST_FIN && out_free, out_valid_q)
  `TSI_ASSERT_IMP(a_shutdown_stops, out_valid_q && out_q.shutdown_now,
                  out_q.emergency && !out_q.process_active)

endmodule
